// ----- src/cnlc_pkg.sv -----
// ----------------------------------------------------------------------------
// cnlc_pkg
// Shared widths, types and control codes for the card number classifier.
// ----------------------------------------------------------------------------
package cnlc_pkg;

  // Binary card number width and decimal digit count of its largest value
  localparam int CARD_W   = 54;
  localparam int DIGITS   = 17;
  localparam int DIGIT_W  = 4;
  localparam int BCD_W    = DIGITS * DIGIT_W;
  localparam int BITCNT_W = $clog2(CARD_W);
  localparam int DIGCNT_W = $clog2(DIGITS + 1);

  typedef logic [CARD_W-1:0]  card_t;
  typedef logic [BCD_W-1:0]   bcd_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [1:0]         verdict_t;

  // Result classes
  localparam verdict_t CLASS_NONE  = 2'd0;
  localparam verdict_t CLASS_FIVES = 2'd1;
  localparam verdict_t CLASS_THREE = 2'd2;
  localparam verdict_t CLASS_FOUR  = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SCAN,
    S_HOLD
  } state_t;

endpackage

// ----- src/cnlc_bcd_conv.sv -----
// ----------------------------------------------------------------------------
// cnlc_bcd_conv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per
// cycle, most significant bit first.
// ----------------------------------------------------------------------------
module cnlc_bcd_conv (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  cnlc_pkg::card_t value,
  output logic            done,
  output cnlc_pkg::bcd_t  bcd
);
  import cnlc_pkg::*;

  logic                busy;
  logic [BITCNT_W-1:0] bit_cnt;
  card_t               bin;
  bcd_t                bcd_adj;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Control: count the input bits while busy, flag the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        bit_cnt <= '0;
      end else if (busy) begin
        bit_cnt <= bit_cnt + BITCNT_W'(1);
        if (bit_cnt == BITCNT_W'(CARD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load, then shift one binary bit into the digits per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (busy) begin
      bcd <= {bcd_adj[BCD_W-2:0], bin[CARD_W-1]};
      bin <= {bin[CARD_W-2:0], 1'b0};
    end
  end

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("conversion done without a run in progress");

  a_start_clears_done: assert property (@(posedge clk) disable iff (rst)
    start |=> !done)
    else $error("done raised right after a start");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> bit_cnt < BITCNT_W'(CARD_W))
    else $error("bit counter ran past the input width");

endmodule

// ----- src/card_number_luhn_classifier.sv -----
// ----------------------------------------------------------------------------
// card_number_luhn_classifier
// Each card number beat passes from acceptance to result through the
// bit-serial binary to decimal converter (one input bit per cycle), a
// hand-over of the decimal digits to the digit scan, the digit scan that
// forms the Luhn sum, the digit count and the leading two digits (one
// decimal digit per cycle), and the registering of the result. The next
// number is taken in the cycle after the result is loaded. One number is
// in work at a time; card_stall is high from acceptance until the result
// is loaded into the output register. A result that waits there does not
// hold up acceptance of the next number, but that number's result waits
// at the end of its scan until the output register is free.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier (
  input  logic                clk,
  input  logic                rst,
  input  logic                card_valid,
  output logic                card_stall,
  input  cnlc_pkg::card_t     card_number,
  output logic                result_valid,
  input  logic                result_stall,
  output cnlc_pkg::verdict_t  verdict,
  output logic                luhn_ok,
  output logic                length_ok
);
  import cnlc_pkg::*;

  state_t              state;
  state_t              state_next;
  logic                conv_start;
  logic                conv_done;
  bcd_t                conv_bcd;
  bcd_t                scan;
  logic [DIGCNT_W-1:0] dig_idx;
  logic [DIGCNT_W-1:0] dig_cnt;
  digit_t              acc;
  digit_t              prev;
  digit_t              lead_hi;
  digit_t              lead_lo;
  digit_t              cur;
  digit_t              term;
  logic [DIGIT_W:0]    sum_raw;
  digit_t              acc_next;
  logic                scan_last;
  logic                out_free;
  logic                load_result;
  logic                len_ok_w;
  logic                luhn_ok_w;
  verdict_t            verdict_w;

  cnlc_bcd_conv u_conv (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .value (card_number),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  // Luhn term of the current digit and the running sum mod 10
  always_comb begin
    cur = scan[DIGIT_W-1:0];
    if (dig_idx[0]) begin
      if (cur >= DIGIT_W'(5)) begin
        term = DIGIT_W'({cur, 1'b0} - (DIGIT_W + 1)'(9));
      end else begin
        term = DIGIT_W'({cur, 1'b0});
      end
    end else begin
      term = cur;
    end
    sum_raw = {1'b0, acc} + {1'b0, term};
    if (sum_raw >= (DIGIT_W + 1)'(10)) begin
      acc_next = DIGIT_W'(sum_raw - (DIGIT_W + 1)'(10));
    end else begin
      acc_next = DIGIT_W'(sum_raw);
    end
  end

  // Result decode from the scan registers
  always_comb begin
    len_ok_w  = (dig_cnt == DIGCNT_W'(13)) || (dig_cnt == DIGCNT_W'(15)) ||
                (dig_cnt == DIGCNT_W'(16));
    luhn_ok_w = (acc == '0);
    verdict_w = CLASS_NONE;
    if (len_ok_w && luhn_ok_w) begin
      if (lead_hi == DIGIT_W'(5) && lead_lo >= DIGIT_W'(1) && lead_lo <= DIGIT_W'(5)) begin
        verdict_w = CLASS_FIVES;
      end else if (lead_hi == DIGIT_W'(3) &&
                   (lead_lo == DIGIT_W'(4) || lead_lo == DIGIT_W'(7))) begin
        verdict_w = CLASS_THREE;
      end else if (lead_hi == DIGIT_W'(4)) begin
        verdict_w = CLASS_FOUR;
      end
    end
  end

  assign scan_last   = (dig_idx == DIGCNT_W'(DIGITS - 1));
  assign out_free    = !result_valid || !result_stall;

  // Next state and handshake controls
  always_comb begin
    state_next  = state;
    card_stall  = 1'b1;
    conv_start  = 1'b0;
    load_result = 1'b0;
    unique case (state)
      S_IDLE: begin
        card_stall = 1'b0;
        if (card_valid) begin
          conv_start = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        if (conv_done) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          load_result = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Digit scan: least significant digit first
  always_ff @(posedge clk) begin
    if (state == S_CONV && conv_done) begin
      scan    <= conv_bcd;
      dig_idx <= '0;
      dig_cnt <= '0;
      acc     <= '0;
      prev    <= '0;
      lead_hi <= '0;
      lead_lo <= '0;
    end else if (state == S_SCAN) begin
      scan    <= {DIGIT_W'(0), scan[BCD_W-1:DIGIT_W]};
      dig_idx <= dig_idx + DIGCNT_W'(1);
      acc     <= acc_next;
      prev    <= cur;
      if (cur != '0) begin
        dig_cnt <= dig_idx + DIGCNT_W'(1);
        lead_hi <= cur;
        lead_lo <= prev;
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      verdict   <= verdict_w;
      luhn_ok   <= luhn_ok_w;
      length_ok <= len_ok_w;
    end
  end

  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    conv_done |-> state == S_CONV)
    else $error("converter finished outside the conversion state");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> dig_idx < DIGCNT_W'(DIGITS))
    else $error("digit index ran past the digit count");

  a_verdict_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid && verdict != CLASS_NONE |-> luhn_ok && length_ok)
    else $error("class given without both checks passing");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    card_valid && !card_stall |=> state == S_CONV)
    else $error("accepted number did not start conversion");

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for card_number_luhn_classifier. Card numbers go in
// through a bursty sender, and results come out through a receiver that
// stalls on a pattern of its own. Each accepted number is classified by a
// local predictor (decimal digits, digit count, Luhn sum, leading-two-digit
// class), and every result beat is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cnlc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int RANDOM_CARDS   = 1100;
  localparam longint unsigned CARD_MASK = (64'd1 << CARD_W) - 64'd1;

  typedef struct packed {
    verdict_t verdict;
    logic     luhn_ok;
    logic     length_ok;
  } card_result_t;

  logic     clk;
  logic     rst          = 1'b1;
  logic     card_valid   = 1'b0;
  logic     card_stall;
  card_t    card_number  = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  verdict_t verdict;
  logic     luhn_ok;
  logic     length_ok;

  card_result_t pending_results[$];
  int           fail_count   = 0;
  int           burst_left   = 0;
  int           idle_cycles  = 0;
  int           stall_mode   = 0;
  int           mode_cycles  = 0;
  int unsigned  stall_phase  = 0;

  card_number_luhn_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .card_valid   (card_valid),
    .card_stall   (card_stall),
    .card_number  (card_number),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .verdict      (verdict),
    .luhn_ok      (luhn_ok),
    .length_ok    (length_ok)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Classify one card number: walk the decimal digits from the right
  function automatic card_result_t classify_card(card_t number);
    longint unsigned rest;
    int           digit;
    int           twice;
    int           digit_count;
    int           luhn_sum;
    int           leading;
    int           prev_digit;
    card_result_t res;
    rest        = longint'(number) & CARD_MASK;
    digit_count = 0;
    luhn_sum    = 0;
    leading     = 0;
    prev_digit  = 0;
    while (rest != 0) begin
      digit = int'(rest % 10);
      rest  = rest / 10;
      digit_count++;
      if (digit_count % 2 == 1) begin
        luhn_sum += digit;
      end else begin
        twice = digit * 2;
        luhn_sum += (twice > 9) ? twice - 9 : twice;
      end
      // the last digit seen is the most significant one
      leading    = digit * 10 + prev_digit;
      prev_digit = digit;
    end
    res.length_ok = (digit_count == 13 || digit_count == 15 || digit_count == 16);
    res.luhn_ok   = (luhn_sum % 10 == 0);
    res.verdict   = CLASS_NONE;
    if (res.length_ok && res.luhn_ok) begin
      if (leading >= 51 && leading <= 55) begin
        res.verdict = CLASS_FIVES;
      end else if (leading == 34 || leading == 37) begin
        res.verdict = CLASS_THREE;
      end else if (leading / 10 == 4) begin
        res.verdict = CLASS_FOUR;
      end
    end
    return res;
  endfunction

  // Build a number from a leading digit group, random middle digits and a
  // final digit that either satisfies the Luhn sum or is random
  function automatic card_t make_card(int unsigned head, int head_len, int total_len,
                                      bit fix_luhn);
    longint unsigned body;
    int              check;
    card_result_t    probe;
    body = head;
    for (int i = head_len; i < total_len - 1; i++) begin
      body = body * 10 + $urandom_range(9);
    end
    body  = body * 10;
    check = 0;
    if (fix_luhn) begin
      probe = classify_card(card_t'(body + check));
      while (!probe.luhn_ok) begin
        check++;
        probe = classify_card(card_t'(body + check));
      end
    end else begin
      check = $urandom_range(9);
    end
    return card_t'(body + check);
  endfunction

  function automatic int valid_length();
    case ($urandom_range(2))
      0:       return 13;
      1:       return 15;
      default: return 16;
    endcase
  endfunction

  // Half well-formed numbers with class prefixes; the rest near misses and noise
  function automatic card_t random_card();
    int unsigned sel;
    int unsigned head;
    int          head_len;
    int          len;
    sel      = $urandom_range(99);
    head_len = 2;
    case ($urandom_range(4))
      0:       head = $urandom_range(51, 55);
      1:       head = 34;
      2:       head = 37;
      3:       head = $urandom_range(40, 49);
      default: begin
        head     = 4;
        head_len = 1;
      end
    endcase
    len = valid_length();
    if (sel < 50) return make_card(head, head_len, len, 1'b1);
    if (sel < 60) begin
      len = $urandom_range(1) ? ($urandom_range(1) ? 12 : 14) : $urandom_range(3, 11);
      return make_card(head, head_len, len, 1'b1);
    end
    if (sel < 70) return make_card($urandom_range(10, 99), 2, len, 1'b1);
    if (sel < 78) return make_card($urandom_range(10, 17), 2, 17, $urandom_range(1) == 1);
    if (sel < 88) return make_card(head, head_len, len, 1'b0);
    if (sel < 92) return card_t'($urandom_range(999));
    return card_t'({$urandom(), $urandom()});
  endfunction

  // Send one card beat, idling between bursts of random length
  task automatic send_card(card_t number);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 120);
      if (gap > 0) begin
        card_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    card_valid  <= 1'b1;
    card_number <= number;
    @(posedge clk);
    while (card_stall) @(posedge clk);
    pending_results.push_back(classify_card(number));
  endtask

  // Hold the sender until every pending result has come back
  task automatic wait_for_drain();
    card_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_special_values();
    send_card(card_t'(0));
    send_card(card_t'(1));
    send_card(card_t'(9));
    send_card(card_t'(CARD_MASK));
    send_card(card_t'(64'd9999999999999999));
    send_card(card_t'(64'd10000000000000000));
    send_card(card_t'(64'd999999999999));
    send_card(card_t'(64'd1000000000000));
  endtask

  task automatic test_class_prefixes();
    send_card(make_card(51, 2, 16, 1'b1));
    send_card(make_card(55, 2, 16, 1'b1));
    send_card(make_card(53, 2, 13, 1'b1));
    send_card(make_card(34, 2, 15, 1'b1));
    send_card(make_card(37, 2, 15, 1'b1));
    send_card(make_card(37, 2, 16, 1'b1));
    send_card(make_card(4, 1, 13, 1'b1));
    send_card(make_card(4, 1, 16, 1'b1));
  endtask

  task automatic test_near_misses();
    send_card(make_card(50, 2, 16, 1'b1));
    send_card(make_card(56, 2, 16, 1'b1));
    send_card(make_card(35, 2, 15, 1'b1));
    send_card(make_card(3, 1, 15, 1'b1));
    send_card(make_card(4, 1, 14, 1'b1));
    send_card(make_card(4, 1, 16, 1'b0));
  endtask

  task automatic test_drain_pause();
    wait_for_drain();
    send_card(make_card(52, 2, 16, 1'b1));
    send_card(make_card(4, 1, 13, 1'b1));
    wait_for_drain();
  endtask

  task automatic test_random_cards(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(150) == 0) wait_for_drain();
      send_card(random_card());
    end
  endtask

  // Receiver stall: switch between no stall, coin flip, heavy and periodic
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (rst) begin
      result_stall <= 1'b0;
      stall_mode   <= 0;
      mode_cycles  <= 0;
    end else begin
      if (mode_cycles == 0) begin
        stall_mode  <= $urandom_range(3);
        mode_cycles <= $urandom_range(100, 600);
      end else begin
        mode_cycles <= mode_cycles - 1;
      end
      case (stall_mode)
        0:       result_stall <= 1'b0;
        1:       result_stall <= ($urandom_range(1) == 1);
        2:       result_stall <= ($urandom_range(9) != 0);
        default: result_stall <= (stall_phase % 16 < 11);
      endcase
    end
  end

  // Compare each result beat against the oldest pending prediction
  always @(posedge clk) begin : check_result
    card_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no card pending: verdict %0d luhn_ok %0b length_ok %0b",
               verdict, luhn_ok, length_ok);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (verdict !== want.verdict) begin
          $error("verdict: expected %0d, actual %0d", want.verdict, verdict);
          fail_count++;
        end
        if (luhn_ok !== want.luhn_ok) begin
          $error("luhn_ok: expected %0b, actual %0b", want.luhn_ok, luhn_ok);
          fail_count++;
        end
        if (length_ok !== want.length_ok) begin
          $error("length_ok: expected %0b, actual %0b", want.length_ok, length_ok);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run after a long stretch with no beat on either side
  always @(posedge clk) begin
    if (rst || (card_valid && !card_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[card_number_luhn_classifier] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_special_values();
    test_class_prefixes();
    test_near_misses();
    test_drain_pause();
    test_random_cards(RANDOM_CARDS);
    // drain, then let any stray beat show up
    card_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[card_number_luhn_classifier] OK");
    end else begin
      $display("[card_number_luhn_classifier] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/cnlc_pkg.sv
src/cnlc_bcd_conv.sv
src/card_number_luhn_classifier.sv
tb/sv/tb_top.sv
